### src/clnw_pkg.sv
// Shared types and constants for the character LCD nibble writer.
package clnw_pkg;

  // Request function codes.
  localparam logic [1:0] FUNC_INIT = 2'd0;
  localparam logic [1:0] FUNC_CMD  = 2'd1;
  localparam logic [1:0] FUNC_CHAR = 2'd2;

  // Character translation constants.
  localparam logic [7:0] BACKSLASH_CODE  = 8'h5C;
  localparam logic [7:0] BACKSLASH_GLYPH = 8'h60;

  // Hold times in milliseconds.
  localparam logic [2:0] SHORT_HOLD = 3'd1;
  localparam logic [2:0] LONG_HOLD  = 3'd5;

  // Nibbles sent during initialisation.
  localparam logic [3:0] INIT_NIBBLE  = 4'h3;
  localparam logic [3:0] INIT_LAST_NIB = 4'h2;

  // Number of entries in the job queue.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified job waiting to be carried out.
  typedef struct packed {
    logic       is_init;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  // Queue status as seen by the front and the back.
  typedef struct packed {
    logic empty;
    logic full;
  } queue_status_t;

  // One pin step on the LCD bus.
  typedef struct packed {
    logic       strobe;
    logic       reg_select;
    logic       read_write;
    logic [3:0] data_nibble;
    logic       enable_level;
    logic [2:0] hold_ms;
    logic       last_step;
  } step_t;

endpackage

### src/clnw_front.sv
// Front end: accepts requests, translates characters and drops requests with no steps.
module clnw_front (
  input  logic                  start,
  input  logic [1:0]            func,
  input  logic [7:0]            code_byte,
  input  clnw_pkg::queue_status_t status,
  output logic                  busy,
  output logic                  push,
  output clnw_pkg::job_t        job
);
  import clnw_pkg::*;

  logic keep;

  // The front is held off only while the queue has no free entry.
  assign busy = status.full;

  // Classify the request and build the job for the back end.
  always_comb begin
    keep         = 1'b0;
    job.is_init  = 1'b0;
    job.rs       = 1'b0;
    job.byte_val = code_byte;
    case (func)
      FUNC_INIT: begin
        keep        = 1'b1;
        job.is_init = 1'b1;
      end
      FUNC_CMD: begin
        keep = 1'b1;
      end
      FUNC_CHAR: begin
        job.rs = 1'b1;
        if (code_byte == BACKSLASH_CODE) begin
          keep         = 1'b1;
          job.byte_val = BACKSLASH_GLYPH;
        end else if (code_byte inside {[8'h20:8'h5B], [8'h5D:8'h5F], [8'h61:8'h7D]}) begin
          keep = 1'b1;
        end
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  // A transaction enters the queue only if it produces steps.
  assign push = start && !busy && keep;

endmodule

### src/clnw_queue.sv
// Short job queue between the front end and the step sequencer.
module clnw_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  clnw_pkg::job_t          push_job,
  input  logic                    pop,
  output clnw_pkg::job_t          pop_job,
  output clnw_pkg::queue_status_t status
);
  import clnw_pkg::*;

  job_t                entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign status.empty = (count == '0);
  assign status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_job      = entries[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers wrap at the queue depth.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### src/clnw_back.sv
// Back end: steps through the nibbles of each job and drives one pin step a cycle while a job is active.
module clnw_back (
  input  logic                    clk,
  input  logic                    rst,
  input  clnw_pkg::queue_status_t status,
  input  clnw_pkg::job_t          pop_job,
  output logic                    pop,
  output clnw_pkg::step_t         step
);
  import clnw_pkg::*;

  // Phase within one nibble.
  localparam logic [1:0] PH_SETUP = 2'd0;
  localparam logic [1:0] PH_HIGH  = 2'd1;
  localparam logic [1:0] PH_LOW   = 2'd2;

  logic       active;
  job_t       job;
  logic [1:0] nib_idx;
  logic [1:0] phase;

  logic [3:0] cur_nibble;
  logic [2:0] cur_hold;
  logic       cur_last;
  logic       run_done;

  // Work out the current step from the job and the position in it.
  always_comb begin
    cur_hold = SHORT_HOLD;
    if (job.is_init) begin
      cur_nibble = (nib_idx == 2'd3) ? INIT_LAST_NIB : INIT_NIBBLE;
      cur_last   = (nib_idx == 2'd3) && (phase == PH_LOW);
      if ((nib_idx == 2'd0) && (phase == PH_LOW)) begin
        cur_hold = LONG_HOLD;
      end
    end else begin
      cur_nibble = (nib_idx == 2'd0) ? job.byte_val[7:4] : job.byte_val[3:0];
      cur_last   = (nib_idx == 2'd1) && (phase == PH_LOW);
    end
  end

  // A new job is taken when idle or on the last step of the current one.
  assign run_done = active && cur_last;
  assign pop      = !status.empty && (!active || run_done);

  // Sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      active      <= 1'b0;
      step.strobe <= 1'b0;
    end else begin
      step.strobe <= active;
      if (pop) begin
        active <= 1'b1;
      end else if (run_done) begin
        active <= 1'b0;
      end
    end
  end

  // Job and position registers.
  always_ff @(posedge clk) begin
    if (pop) begin
      job     <= pop_job;
      nib_idx <= '0;
      phase   <= PH_SETUP;
    end else if (active) begin
      if (phase == PH_LOW) begin
        phase   <= PH_SETUP;
        nib_idx <= nib_idx + 1'b1;
      end else begin
        phase <= phase + 1'b1;
      end
    end
  end

  // Registered pin step outputs.
  always_ff @(posedge clk) begin
    if (active) begin
      step.reg_select   <= job.rs;
      step.read_write   <= 1'b0;
      step.data_nibble  <= cur_nibble;
      step.enable_level <= (phase == PH_HIGH);
      step.hold_ms      <= cur_hold;
      step.last_step    <= cur_last;
    end
  end

endmodule

### src/char_lcd_nibble_writer_top.sv
// Top level of the character LCD nibble writer.
//
// A request is taken at a rising edge with start high and busy low. func selects
// initialise (0), command byte (1) or display character (2); code_byte carries the
// byte. Function code 3 and characters outside the displayable set are taken and
// give no steps. Each request becomes a run of pin steps on the result ports, one
// step a cycle, each shown for a single cycle with strobe high; last_step marks the
// end of a run. A byte gives 6 steps, initialisation 12.
// The first step appears after the job queue, the sequencer's job register and the
// step output register. While the queue holds the next job, runs follow one another
// without a gap, so the sustained rate is one step a cycle, set by the step sequencer.
// A two-entry job queue sits between the front end and the sequencer; busy is
// high while it is full.
// Reset clears the queue and the sequencer; no step is shown during reset.
// The receiver cannot stall: every strobed step is taken in its cycle.
module char_lcd_nibble_writer_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func,
  input  logic [7:0] code_byte,
  output logic       strobe,
  output logic       reg_select,
  output logic       read_write,
  output logic [3:0] data_nibble,
  output logic       enable_level,
  output logic [2:0] hold_ms,
  output logic       last_step
);
  import clnw_pkg::*;

  queue_status_t status;
  job_t          push_job;
  job_t          pop_job;
  logic          push;
  logic          pop;
  step_t         step;

  // Request classification.
  clnw_front u_front (
    .start     (start),
    .func      (func),
    .code_byte (code_byte),
    .status    (status),
    .busy      (busy),
    .push      (push),
    .job       (push_job)
  );

  // Job queue.
  clnw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .status   (status)
  );

  // Step sequencer.
  clnw_back u_back (
    .clk     (clk),
    .rst     (rst),
    .status  (status),
    .pop_job (pop_job),
    .pop     (pop),
    .step    (step)
  );

  assign strobe       = step.strobe;
  assign reg_select   = step.reg_select;
  assign read_write   = step.read_write;
  assign data_nibble  = step.data_nibble;
  assign enable_level = step.enable_level;
  assign hold_ms      = step.hold_ms;
  assign last_step    = step.last_step;

endmodule

### src/clnw_checker.sv
// Port-level checks on the step stream of the nibble writer, bound to the top level.
module clnw_checker (
  input logic       clk,
  input logic       rst,
  input logic       strobe,
  input logic       reg_select,
  input logic       read_write,
  input logic [3:0] data_nibble,
  input logic       enable_level,
  input logic [2:0] hold_ms,
  input logic       last_step
);

  // A run is never broken: a step that is not the last is followed by another.
  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_step |=> strobe)
    else $error("pin step run broken before its last step");

  // Each enable pulse is followed by its falling step on the same nibble.
  a_pulse_fall: assert property (@(posedge clk) disable iff (rst)
    strobe && enable_level |=> strobe && !enable_level &&
    (data_nibble == $past(data_nibble)))
    else $error("enable pulse not closed on the same nibble");

  // Register select stays fixed within one run.
  a_rs_stable: assert property (@(posedge clk) disable iff (rst)
    strobe && !last_step |=> reg_select == $past(reg_select))
    else $error("register select changed within a run");

  // The long hold only ends the first initialisation pulse.
  a_long_hold: assert property (@(posedge clk) disable iff (rst)
    strobe && (hold_ms != 3'd1) |->
    (hold_ms == 3'd5) && !enable_level && !reg_select && (data_nibble == 4'h3) &&
    !last_step && !read_write)
    else $error("unexpected hold time");

endmodule

bind char_lcd_nibble_writer_top clnw_checker u_clnw_checker (
  .clk          (clk),
  .rst          (rst),
  .strobe       (strobe),
  .reg_select   (reg_select),
  .read_write   (read_write),
  .data_nibble  (data_nibble),
  .enable_level (enable_level),
  .hold_ms      (hold_ms),
  .last_step    (last_step)
);

### test/testbench.sv
// Self-checking testbench for the character LCD nibble writer top level.
`timescale 1ns / 1ps

module testbench;
  import clnw_pkg::*;

  // Function code that the block takes and ignores.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Number of random requests queued after the directed ones.
  localparam int RANDOM_ITEMS = 180;
  // Cycles to wait once nothing more is expected.
  localparam int DRAIN_CYCLES = 40;

  // One request as the driver presents it.
  typedef struct {
    logic [1:0] func;
    logic [7:0] code_byte;
  } lcd_request_t;

  // One pin step as the block should show it.
  typedef struct {
    logic       reg_select;
    logic       read_write;
    logic [3:0] data_nibble;
    logic       enable_level;
    logic [2:0] hold_ms;
    logic       last_step;
  } pin_step_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       start = 1'b0;
  logic [1:0] func = FUNC_INIT;
  logic [7:0] code_byte = 8'h00;
  logic       busy;
  logic       strobe;
  logic       reg_select;
  logic       read_write;
  logic [3:0] data_nibble;
  logic       enable_level;
  logic [2:0] hold_ms;
  logic       last_step;

  lcd_request_t request_queue[$];
  pin_step_t    pending_steps[$];
  lcd_request_t next_request;
  pin_step_t    want_step;
  int           idle_left = 0;
  int           sent_count = 0;
  bit           steady_phase = 1'b0;
  int           mismatches = 0;

  char_lcd_nibble_writer_top i_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .func         (func),
    .code_byte    (code_byte),
    .strobe       (strobe),
    .reg_select   (reg_select),
    .read_write   (read_write),
    .data_nibble  (data_nibble),
    .enable_level (enable_level),
    .hold_ms      (hold_ms),
    .last_step    (last_step)
  );

  // Clock with a 2 ns period.
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Prints one line for a failed check and counts it.
  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("MISMATCH at %0t ns: %s got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatches++;
  endtask

  // Maps a character code onto the display glyph; returns 0 if the code is dropped.
  function automatic bit char_to_glyph(input logic [7:0] c, output logic [7:0] glyph);
    glyph = c;
    if (c == BACKSLASH_CODE) begin
      glyph = BACKSLASH_GLYPH;
      return 1'b1;
    end
    return (c >= 8'h20 && c <= 8'h5B) || (c >= 8'h5D && c <= 8'h5F) ||
           (c >= 8'h61 && c <= 8'h7D);
  endfunction

  // Queues the three steps of one nibble: set-up, enable high, enable low.
  task automatic push_nibble(input logic rs, input logic [3:0] nib,
                             input logic [2:0] tail_hold, input logic is_last);
    pending_steps.push_back('{rs, 1'b0, nib, 1'b0, SHORT_HOLD, 1'b0});
    pending_steps.push_back('{rs, 1'b0, nib, 1'b1, SHORT_HOLD, 1'b0});
    pending_steps.push_back('{rs, 1'b0, nib, 1'b0, tail_hold, is_last});
  endtask

  // Works out the pin steps that one accepted request should give.
  task automatic predict_lcd_steps(input logic [1:0] f, input logic [7:0] c);
    logic [7:0] glyph;
    case (f)
      FUNC_INIT: begin
        push_nibble(1'b0, INIT_NIBBLE, LONG_HOLD, 1'b0);
        push_nibble(1'b0, INIT_NIBBLE, SHORT_HOLD, 1'b0);
        push_nibble(1'b0, INIT_NIBBLE, SHORT_HOLD, 1'b0);
        push_nibble(1'b0, INIT_LAST_NIB, SHORT_HOLD, 1'b1);
      end
      FUNC_CMD: begin
        push_nibble(1'b0, c[7:4], SHORT_HOLD, 1'b0);
        push_nibble(1'b0, c[3:0], SHORT_HOLD, 1'b1);
      end
      FUNC_CHAR: begin
        if (char_to_glyph(c, glyph)) begin
          push_nibble(1'b1, glyph[7:4], SHORT_HOLD, 1'b0);
          push_nibble(1'b1, glyph[3:0], SHORT_HOLD, 1'b1);
        end
      end
      default: begin
        // The unused function code gives no steps.
      end
    endcase
  endtask

  // Picks the pause after a transaction: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // Driver: records each accepted transaction and presents the next request.
  always @(posedge clk) begin
    if (rst) begin
      start     <= 1'b0;
      idle_left <= 0;
    end else begin
      if (start && !busy) begin
        predict_lcd_steps(func, code_byte);
        sent_count++;
        if (sent_count % 40 == 0) steady_phase = !steady_phase;
      end
      if (start && busy) begin
        // Hold the request until the block takes it.
      end else if (idle_left > 0) begin
        start     <= 1'b0;
        idle_left <= idle_left - 1;
      end else if (request_queue.size() > 0) begin
        next_request = request_queue.pop_front();
        start        <= 1'b1;
        func         <= next_request.func;
        code_byte    <= next_request.code_byte;
        idle_left    <= steady_phase ? 0 : pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: compares every strobed step with the oldest expected one.
  always @(posedge clk) begin
    if (!rst && strobe) begin
      if (pending_steps.size() == 0) begin
        report_mismatch("step with nothing expected, nibble", 8'(data_nibble), 8'h00);
      end else begin
        want_step = pending_steps.pop_front();
        if (reg_select !== want_step.reg_select)
          report_mismatch("reg_select", 8'(reg_select), 8'(want_step.reg_select));
        if (read_write !== want_step.read_write)
          report_mismatch("read_write", 8'(read_write), 8'(want_step.read_write));
        if (data_nibble !== want_step.data_nibble)
          report_mismatch("data_nibble", 8'(data_nibble), 8'(want_step.data_nibble));
        if (enable_level !== want_step.enable_level)
          report_mismatch("enable_level", 8'(enable_level), 8'(want_step.enable_level));
        if (hold_ms !== want_step.hold_ms)
          report_mismatch("hold_ms", 8'(hold_ms), 8'(want_step.hold_ms));
        if (last_step !== want_step.last_step)
          report_mismatch("last_step", 8'(last_step), 8'(want_step.last_step));
      end
    end
  end

  // Stimulus, reset and the end of the run.
  initial begin
    int         r;
    logic [1:0] f;
    logic [7:0] c;

    // Directed part: every function, byte extremes and the edges of the character set.
    request_queue.push_back('{FUNC_INIT, 8'h00});
    request_queue.push_back('{FUNC_CMD, 8'h00});
    request_queue.push_back('{FUNC_CMD, 8'hFF});
    request_queue.push_back('{FUNC_CMD, 8'hA5});
    request_queue.push_back('{FUNC_CMD, 8'h5A});
    request_queue.push_back('{FUNC_CHAR, BACKSLASH_CODE});
    request_queue.push_back('{FUNC_CHAR, 8'h1F});
    request_queue.push_back('{FUNC_CHAR, 8'h20});
    request_queue.push_back('{FUNC_CHAR, 8'h5B});
    request_queue.push_back('{FUNC_CHAR, 8'h5D});
    request_queue.push_back('{FUNC_CHAR, 8'h5F});
    request_queue.push_back('{FUNC_CHAR, 8'h60});
    request_queue.push_back('{FUNC_CHAR, 8'h61});
    request_queue.push_back('{FUNC_CHAR, 8'h7D});
    request_queue.push_back('{FUNC_CHAR, 8'h7E});
    request_queue.push_back('{FUNC_CHAR, 8'h00});
    request_queue.push_back('{FUNC_CHAR, 8'hFF});
    request_queue.push_back('{FUNC_CHAR, 8'hDC});
    request_queue.push_back('{FUNC_UNUSED, 8'hFF});
    request_queue.push_back('{FUNC_UNUSED, 8'h00});
    request_queue.push_back('{FUNC_INIT, 8'hFF});
    request_queue.push_back('{FUNC_CHAR, 8'h41});

    // Random part: a mix of all functions, characters mostly printable.
    repeat (RANDOM_ITEMS) begin
      r = $urandom_range(0, 99);
      c = 8'($urandom_range(0, 255));
      if (r < 15) begin
        f = FUNC_INIT;
      end else if (r < 50) begin
        f = FUNC_CMD;
      end else if (r < 90) begin
        f = FUNC_CHAR;
        if (r < 75) c = 8'($urandom_range(8'h20, 8'h7D));
      end else begin
        f = FUNC_UNUSED;
      end
      request_queue.push_back('{f, c});
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Wait for every transaction to be taken and every step to arrive.
    while (request_queue.size() > 0) @(posedge clk);
    @(posedge clk);
    while (start) @(posedge clk);
    while (pending_steps.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && pending_steps.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Guard against a hung run.
  initial begin
    #200000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
